### design/hpt_pkg.sv
// hpt_pkg: shared constants for the homogeneous point transform
// configuration register indexes and fixed format constants
// no dependencies
`default_nettype none
package hpt_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW0 = 3'd0,
    CFG_ROW1 = 3'd1,
    CFG_ROW2 = 3'd2,
    CFG_ROW3 = 3'd3
  } cfg_idx_t;

  // coordinate fraction bits and coefficient integer bits
  localparam int unsigned COORD_FRAC = 16;
  localparam int unsigned COEF_INT   = 4;
  localparam int unsigned LANES      = 4;

endpackage
`default_nettype wire

### design/hpt_dot_lane.sv
// hpt_dot_lane: one matrix row times the input vector
// four registered multiplies, then a registered sum rounded to 16 fraction bits
// depends on hpt_pkg
`default_nettype none
module hpt_dot_lane import hpt_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned COEF_WIDTH  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [LANES*COEF_WIDTH-1:0]       row,
  input  wire logic signed [COORD_WIDTH:0]       c0,
  input  wire logic signed [COORD_WIDTH:0]       c1,
  input  wire logic signed [COORD_WIDTH:0]       c2,
  input  wire logic signed [COORD_WIDTH:0]       c3,
  output logic signed [COORD_WIDTH+COEF_INT+2:0] dot
);
  localparam int unsigned CW = COORD_WIDTH + 1;
  localparam int unsigned PW = CW + COEF_WIDTH;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned F  = COEF_WIDTH - COEF_INT;
  localparam int unsigned RW = SW - F;

  logic signed [PW-1:0] prod_r [LANES];
  logic signed [CW-1:0] cv [LANES];
  logic signed [SW-1:0] sum;
  logic signed [RW-1:0] dot_r;

  assign cv[0] = c0;
  assign cv[1] = c1;
  assign cv[2] = c2;
  assign cv[3] = c3;

  // products, one multiplier per coefficient
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LANES; k++) begin
        prod_r[k] <= signed'(row[k*COEF_WIDTH +: COEF_WIDTH]) * cv[k];
      end
    end
  end

  // exact sum, round half up, drop fraction bits
  always_comb begin
    sum = SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2]) + SW'(prod_r[3])
        + (SW'(1) << (F - 1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot_r <= RW'(sum >>> F);
    end
  end

  assign dot = dot_r;

endmodule
`default_nettype wire

### design/hpt_div_lane.sv
// hpt_div_lane: pipelined restoring divider, one quotient bit per stage
// gives num/den with 16 fraction bits, rounded half away from zero, saturated
// depends on hpt_pkg
`default_nettype none
module hpt_div_lane import hpt_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned IN_WIDTH    = 39
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [IN_WIDTH-1:0]    num,
  input  wire logic signed [IN_WIDTH-1:0]    den,
  output logic        [COORD_WIDTH-1:0]      quot,
  output logic                               sat
);
  localparam int unsigned N   = COORD_WIDTH;
  localparam int unsigned DW  = IN_WIDTH + N;
  localparam int unsigned RMW = DW + 1;
  localparam int unsigned QW  = N + 1;
  localparam int unsigned NST = N + 1;

  logic [IN_WIDTH-1:0] n_abs, d_abs;
  logic                big;

  logic [RMW-1:0] rem_r [NST+1];
  logic [DW-1:0]  dsh_r [NST+1];
  logic [QW-1:0]  q_r   [NST+1];
  logic           neg_r [NST+1];
  logic           big_r [NST+1];

  // magnitudes and integer overflow check
  always_comb begin
    n_abs = num[IN_WIDTH-1] ? IN_WIDTH'(-num) : IN_WIDTH'(num);
    d_abs = den[IN_WIDTH-1] ? IN_WIDTH'(-den) : IN_WIDTH'(den);
    big   = DW'(n_abs) >= (DW'(d_abs) << (N - COORD_FRAC));
  end

  // setup stage
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= RMW'(n_abs) << (COORD_FRAC + 1);
      dsh_r[0] <= DW'(d_abs) << N;
      q_r[0]   <= '0;
      neg_r[0] <= num[IN_WIDTH-1] ^ den[IN_WIDTH-1];
      big_r[0] <= big;
    end
  end

  // one quotient bit per stage
  for (genvar j = 0; j < NST; j++) begin : g_stage
    logic          ge;
    logic [RMW-1:0] diff;
    always_comb begin
      ge   = rem_r[j] >= RMW'(dsh_r[j]);
      diff = ge ? (rem_r[j] - RMW'(dsh_r[j])) : rem_r[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= diff << 1;
        dsh_r[j+1] <= dsh_r[j];
        q_r[j+1]   <= {q_r[j][QW-2:0], ge};
        neg_r[j+1] <= neg_r[j];
        big_r[j+1] <= big_r[j];
      end
    end
  end

  // round, apply sign, clip
  logic [QW-1:0] mag;
  logic          over;
  always_comb begin
    mag  = (q_r[NST] >> 1) + QW'(q_r[NST][0]);
    over = neg_r[NST] ? (mag > (QW'(1) << (N - 1)))
                      : (mag > ((QW'(1) << (N - 1)) - QW'(1)));
    sat  = big_r[NST] | over;
    if (sat) begin
      quot = neg_r[NST] ? {1'b1, {(N-1){1'b0}}} : {1'b0, {(N-1){1'b1}}};
    end else begin
      quot = neg_r[NST] ? N'(-mag) : N'(mag);
    end
  end

endmodule
`default_nettype wire

### design/homogeneous_point_transform.sv
// homogeneous_point_transform: 4x4 fixed-point matrix times vector, optional divide
// top level with configuration registers, row lanes, divider lanes and merge stage
// depends on hpt_pkg, hpt_dot_lane, hpt_div_lane
//
// usage:
//   in_*  beats carry x, y, z, w (tdata, x lowest) and the mode (tuser);
//   mode 1 treats the input as a point with w = 1 and divides x, y, z by the
//   computed w. out_* beats carry x, y, z, w and the flags saturated and
//   divide_by_zero in tuser. cfg_* writes one matrix row per write;
//   the user must write only while idle; the block does not enforce it.
//   throughput: one beat per clock unless the receiver stalls. an accepted
//   input beat passes the multiply and sum registers, a setup stage,
//   COORD_WIDTH + 1 quotient-bit stages of the divider and the output
//   register. every beat takes the full pipeline in both modes. the whole
//   pipeline advances together: when the receiver stalls with a result
//   waiting, in_tready drops until that result is taken; empty slots still
//   fill while the output register is free. reset (synchronous, active low)
//   empties the pipeline and loads the identity matrix.
`default_nettype none
module homogeneous_point_transform import hpt_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned COEF_WIDTH  = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // input channel
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // fields from bit 0: in_x, in_y, in_z, in_w
  input  wire logic [((4*COORD_WIDTH+7)/8)*8-1:0]     in_tdata,
  // fields from bit 0: mode
  input  wire logic                                   in_tuser,
  // result channel
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // fields from bit 0: out_x, out_y, out_z, out_w
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0]          out_tdata,
  // fields from bit 0: saturated, divide_by_zero
  output logic [1:0]                                  out_tuser,
  // configuration port
  input  wire logic                                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]                   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]                  cfg_wdata
);
  localparam int unsigned N       = COORD_WIDTH;
  localparam int unsigned TDW     = ((4*N+7)/8)*8;
  localparam int unsigned RW      = N + COEF_INT + 3;
  localparam int unsigned ROWW    = LANES * COEF_WIDTH;
  localparam int unsigned DIV_LAT = N + 2;
  localparam int unsigned PIPE    = DIV_LAT + 2;
  localparam logic [ROWW-1:0] ONE = ROWW'(1) << (COEF_WIDTH - COEF_INT);

  typedef struct packed {
    logic         mode;
    logic         dz;
    logic         sat_w;
    logic         sat_xyz;
    logic [N-1:0] x;
    logic [N-1:0] y;
    logic [N-1:0] z;
    logic [N-1:0] w;
  } side_t;

  logic en;
  logic accept;

  // matrix rows
  logic [ROWW-1:0] row_r [LANES];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= ONE;
      row_r[1] <= ONE << COEF_WIDTH;
      row_r[2] <= ONE << (2*COEF_WIDTH);
      row_r[3] <= ONE << (3*COEF_WIDTH);
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROW0: row_r[0] <= ROWW'(cfg_wdata);
        CFG_ROW1: row_r[1] <= ROWW'(cfg_wdata);
        CFG_ROW2: row_r[2] <= ROWW'(cfg_wdata);
        CFG_ROW3: row_r[3] <= ROWW'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // global advance
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;
  assign accept    = in_tvalid && en;

  // valid and mode chain
  logic [PIPE-1:0] vld_r;
  logic [1:0]      mode_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE-2:0], accept};
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mode_r <= {mode_r[0], in_tuser};
    end
  end

  // vector entries, w forced to one for points
  logic signed [N:0] cx, cy, cz, cw;
  always_comb begin
    cx = (N+1)'(signed'(in_tdata[0*N +: N]));
    cy = (N+1)'(signed'(in_tdata[1*N +: N]));
    cz = (N+1)'(signed'(in_tdata[2*N +: N]));
    cw = in_tuser ? ((N+1)'(1) << COORD_FRAC) : (N+1)'(signed'(in_tdata[3*N +: N]));
  end

  // row lanes
  logic signed [RW-1:0] dot [LANES];
  for (genvar r = 0; r < LANES; r++) begin : g_row
    hpt_dot_lane #(.COORD_WIDTH(N), .COEF_WIDTH(COEF_WIDTH)) u_row (
      .clk (clk),
      .en  (en),
      .row (row_r[r]),
      .c0  (cx),
      .c1  (cy),
      .c2  (cz),
      .c3  (cw),
      .dot (dot[r])
    );
  end

  // divider lanes for x, y, z
  logic [N-1:0] quot [3];
  logic         qsat [3];
  for (genvar r = 0; r < 3; r++) begin : g_div
    hpt_div_lane #(.COORD_WIDTH(N), .IN_WIDTH(RW)) u_div (
      .clk  (clk),
      .en   (en),
      .num  (dot[r]),
      .den  (dot[3]),
      .quot (quot[r]),
      .sat  (qsat[r])
    );
  end

  function automatic logic clip_ovf(input logic signed [RW-1:0] v);
    clip_ovf = !((&v[RW-1:N-1]) || !(|v[RW-1:N-1]));
  endfunction

  function automatic logic [N-1:0] clip_val(input logic signed [RW-1:0] v);
    if (clip_ovf(v)) begin
      clip_val = v[RW-1] ? {1'b1, {(N-1){1'b0}}} : {1'b0, {(N-1){1'b1}}};
    end else begin
      clip_val = v[N-1:0];
    end
  endfunction

  // sideband from the row sums, delayed alongside the dividers
  side_t side;
  side_t side_r [DIV_LAT];
  always_comb begin
    side.mode    = mode_r[1];
    side.dz      = mode_r[1] && (dot[3] == '0);
    side.sat_w   = clip_ovf(dot[3]);
    side.sat_xyz = clip_ovf(dot[0]) | clip_ovf(dot[1]) | clip_ovf(dot[2]);
    side.x       = clip_val(dot[0]);
    side.y       = clip_val(dot[1]);
    side.z       = clip_val(dot[2]);
    side.w       = clip_val(dot[3]);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // merge stage and output register
  side_t        fin;
  logic [N-1:0] rx_nxt, ry_nxt, rz_nxt;
  logic         sat_nxt;
  always_comb begin
    fin = side_r[DIV_LAT-1];
    if (!fin.mode) begin
      rx_nxt  = fin.x;
      ry_nxt  = fin.y;
      rz_nxt  = fin.z;
      sat_nxt = fin.sat_w | fin.sat_xyz;
    end else if (fin.dz) begin
      rx_nxt  = '0;
      ry_nxt  = '0;
      rz_nxt  = '0;
      sat_nxt = fin.sat_w;
    end else begin
      rx_nxt  = quot[0];
      ry_nxt  = quot[1];
      rz_nxt  = quot[2];
      sat_nxt = fin.sat_w | qsat[0] | qsat[1] | qsat[2];
    end
  end

  logic             out_valid_r;
  logic [4*N-1:0]   out_data_r;
  logic [1:0]       out_user_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[PIPE-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {fin.w, rz_nxt, ry_nxt, rx_nxt};
      out_user_r <= {fin.dz, sat_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDW'(out_data_r);
  assign out_tuser  = out_user_r;

  // checks
  a_dz_zero_xyz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[3*N-1:0] == '0)
    else $error("divide by zero beat with nonzero x, y or z");
  a_dz_zero_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[4*N-1:3*N] == '0)
    else $error("divide by zero beat with nonzero w");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

### tb/homogeneous_point_transform_tb.sv
// homogeneous_point_transform_tb: self-checking bench for the 4x4 point transform
// predicts each result from its own copy of the matrix, checks beats in order
// depends on hpt_pkg and homogeneous_point_transform
`default_nettype none
module homogeneous_point_transform_tb;
  import hpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam int KW = 16;
  localparam int KFRAC = KW - COEF_INT;
  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;
  localparam int LATENCY = CW + 5;

  typedef struct packed {
    logic [CW-1:0] w;
    logic [CW-1:0] z;
    logic [CW-1:0] y;
    logic [CW-1:0] x;
    logic [1:0]    flags;  // divide_by_zero, saturated
  } xform_result_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [4*CW-1:0] in_tdata = '0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [4*CW-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_wr_en = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [63:0] matrix_rows [4];
  xform_result_t expected_vertices [$];
  int errors = 0;
  bit stall_enable = 1;

  homogeneous_point_transform #(.COORD_WIDTH(CW), .COEF_WIDTH(KW)) dut (.*);

  initial forever #5 clk = ~clk;

  // generous run limit
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  // exact dot product, one rounding to nearest, ties up
  function automatic longint row_dot(logic [63:0] row, longint c [4]);
    longint acc;
    acc = 0;
    for (int k = 0; k < 4; k++)
      acc += longint'($signed(row[k*KW +: KW])) * c[k];
    return (acc + (64'sd1 <<< (KFRAC - 1))) >>> KFRAC;
  endfunction

  function automatic logic [CW-1:0] clip(longint v, ref bit sat);
    if (v > CMAX) begin sat = 1; return CMAX[CW-1:0]; end
    if (v < CMIN) begin sat = 1; return CMIN[CW-1:0]; end
    return v[CW-1:0];
  endfunction

  // quotient with 16 fraction bits, rounded half away from zero
  function automatic logic [CW-1:0] divide_q16(longint num, longint den, ref bit sat);
    bit neg;
    logic [127:0] n, d, q, r;
    longint mag;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = (n << COORD_FRAC) / d;
    r = (n << COORD_FRAC) % d;
    if ((r << 1) >= d) q += 1;
    if (q > 128'h7fff_ffff_ffff) begin
      sat = 1;
      return neg ? CMIN[CW-1:0] : CMAX[CW-1:0];
    end
    mag = q[63:0];
    return clip(neg ? -mag : mag, sat);
  endfunction

  function automatic xform_result_t transform_vertex(bit point, logic [4*CW-1:0] v);
    longint c [4];
    longint s [4];
    bit sat, dz;
    xform_result_t res;
    sat = 0; dz = 0;
    for (int k = 0; k < 4; k++) c[k] = longint'($signed(v[k*CW +: CW]));
    if (point) c[3] = 64'sd1 <<< COORD_FRAC;
    for (int r = 0; r < 4; r++) s[r] = row_dot(matrix_rows[r], c);
    res.w = clip(s[3], sat);
    if (!point) begin
      res.x = clip(s[0], sat);
      res.y = clip(s[1], sat);
      res.z = clip(s[2], sat);
    end else if (s[3] == 0) begin
      dz = 1;
      res.x = '0; res.y = '0; res.z = '0;
    end else begin
      res.x = divide_q16(s[0], s[3], sat);
      res.y = divide_q16(s[1], s[3], sat);
      res.z = divide_q16(s[2], s[3], sat);
    end
    res.flags = {dz, sat};
    return res;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // send one vertex beat and queue its prediction
  task automatic send_vertex(bit point, logic [4*CW-1:0] v);
    int g;
    g = stall_enable ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= v;
    in_tuser <= point;
    do @(posedge clk); while (!in_tready);
    expected_vertices.push_back(transform_vertex(point, v));
    @(negedge clk);
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_tvalid <= 0;
    while (expected_vertices.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_row(cfg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    matrix_rows[idx] = val;
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  function automatic logic [15:0] rnd_coef();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'(1 << KFRAC);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CW-1:0] rnd_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
      4: return 32'($signed($urandom_range(0, 512)) - 256);
      default: return $urandom;
    endcase
  endfunction

  task automatic load_matrix(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                             logic [63:0] r3);
    drain();
    write_row(CFG_ROW0, r0);
    write_row(CFG_ROW1, r1);
    write_row(CFG_ROW2, r2);
    write_row(CFG_ROW3, r3);
  endtask

  // result checker
  always @(posedge clk) begin
    xform_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_vertices.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        exp_res = expected_vertices.pop_front();
        if (out_tdata[0 +: CW] !== exp_res.x) begin
          $error("out_x expected %h actual %h", exp_res.x, out_tdata[0 +: CW]); errors++;
        end
        if (out_tdata[CW +: CW] !== exp_res.y) begin
          $error("out_y expected %h actual %h", exp_res.y, out_tdata[CW +: CW]); errors++;
        end
        if (out_tdata[2*CW +: CW] !== exp_res.z) begin
          $error("out_z expected %h actual %h", exp_res.z, out_tdata[2*CW +: CW]); errors++;
        end
        if (out_tdata[3*CW +: CW] !== exp_res.w) begin
          $error("out_w expected %h actual %h", exp_res.w, out_tdata[3*CW +: CW]); errors++;
        end
        if (out_tuser[0] !== exp_res.flags[0]) begin
          $error("saturated expected %b actual %b", exp_res.flags[0], out_tuser[0]); errors++;
        end
        if (out_tuser[1] !== exp_res.flags[1]) begin
          $error("divide_by_zero expected %b actual %b", exp_res.flags[1], out_tuser[1]);
          errors++;
        end
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    int g;
    if (!stall_enable) out_tready <= 1;
    else begin
      g = gap_len();
      out_tready <= (g == 0);
    end
  end

  // identity matrix, field extremes in both modes
  task automatic test_identity_extremes();
    send_vertex(0, {32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0001_0000});
    send_vertex(0, {32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0001});
    send_vertex(1, {32'h1234_5678, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_0000});
    send_vertex(1, {32'h0, 32'h0, 32'h0, 32'h0});
  endtask

  // scale up to force saturation, negative and positive
  task automatic test_saturation();
    load_matrix({48'h0, 16'h7fff}, {32'h0, 16'h8000, 16'h0},
                {16'h0, 16'h7fff, 32'h0}, {16'h7fff, 48'h0});
    send_vertex(0, {32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
    send_vertex(0, {32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
    send_vertex(1, {32'h0, 32'h0100_0000, 32'h8000_0000, 32'h7fff_ffff});
    send_vertex(0, {32'h0001_0000, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001});
  endtask

  // perspective divide with tiny w, rounding ties
  task automatic test_divide();
    load_matrix(64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
                64'h0000_1000_0000_0000, 64'h1000_0000_1000_0000);
    send_vertex(1, {32'h0, 32'h0001_0000, 32'h0002_0000, 32'hffff_0000});
    send_vertex(1, {32'h0, 32'hffff_0000, 32'h0003_0000, 32'h0005_0000});
    send_vertex(1, {32'h0, 32'hffff_0001, 32'h7fff_ffff, 32'h8000_0000});
    send_vertex(1, {32'h0, 32'hfffe_0000, 32'h0000_8000, 32'h0001_8000});
    send_vertex(1, {32'h0, 32'hffff_0000, 32'h0000_0001, 32'h0000_0003});
    send_vertex(0, {32'h1, 32'hffff_0000, 32'h1, 32'h1});
    load_matrix(64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
                64'h0000_1000_0000_0000, 64'h0000_0000_0000_0001);
    send_vertex(1, {32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_1000});
    send_vertex(1, {32'h0, 32'h0, 32'h0, 32'h0000_0800});
    send_vertex(1, {32'h0, 32'h1, 32'h1, 32'hffff_f7ff});
  endtask

  // random matrices and vectors, sweeping idle patterns, then one fixed matrix
  task automatic test_random();
    for (int phase = 0; phase < 15; phase++) begin
      load_matrix({rnd_coef(), rnd_coef(), rnd_coef(), rnd_coef()},
                  {rnd_coef(), rnd_coef(), rnd_coef(), rnd_coef()},
                  {rnd_coef(), rnd_coef(), rnd_coef(), rnd_coef()},
                  {rnd_coef(), rnd_coef(), rnd_coef(), rnd_coef()});
      stall_enable = (phase % 4 != 3);
      for (int i = 0; i < 103; i++)
        send_vertex($urandom_range(0, 1),
                    {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()});
      stall_enable = 1;
    end
    load_matrix(64'hffff_ffff_ffff_ffff, 64'h0, 64'h8000_8000_8000_8000,
                64'h7fff_7fff_7fff_7fff);
    for (int i = 0; i < 20; i++)
      send_vertex($urandom_range(0, 1), {$urandom, $urandom, $urandom, $urandom});
  endtask

  initial begin
    matrix_rows[0] = 64'h0000_0000_0000_1000;
    matrix_rows[1] = 64'h0000_0000_1000_0000;
    matrix_rows[2] = 64'h0000_1000_0000_0000;
    matrix_rows[3] = 64'h1000_0000_0000_0000;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    test_identity_extremes();
    test_saturation();
    test_divide();
    test_random();
    drain();
    if (errors == 0 && expected_vertices.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
